FILE: src/boh_pkg.sv
// ----------------------------------------------------------------------------
// boh_pkg
// Shared types and constants of the busy-occupancy histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package boh_pkg;

  // Default configuration
  localparam int NumClustersDef = 8;
  localparam int NumUnitsDef    = 8;
  localparam int CountBitsDef   = 48;

  // Fixed field widths
  localparam int BusyW    = 4;
  localparam int IdxW     = 4;
  localparam int BankW    = 2;
  localparam int OutW     = 48;
  // Compare width for bins and indexes (holds values up to 255)
  localparam int CmpW     = 8;
  // Widest counter, used when resizing to the output field
  localparam int MaxCntW  = 64;

  // Command codes
  localparam logic CmdTick = 1'b0;
  localparam logic CmdRead = 1'b1;

  // Totals
  localparam int NumTotals = 4;
  localparam int TotIdxW   = 2;
  localparam logic [TotIdxW-1:0] TotUnit    = 2'd0;
  localparam logic [TotIdxW-1:0] TotDma     = 2'd1;
  localparam logic [TotIdxW-1:0] TotCluster = 2'd2;
  localparam logic [TotIdxW-1:0] TotUnitDma = 2'd3;

  // Read banks
  typedef enum logic [BankW-1:0] {
    BankCluster = 2'd0,
    BankDma     = 2'd1,
    BankUnit    = 2'd2,
    BankTotal   = 2'd3
  } boh_bank_e;

  // Control from the top level to one histogram
  typedef struct packed {
    logic rd_en;   // read the entry at rd_addr into the pipeline register
    logic inc_en;  // write back the incremented entry read in the previous cycle
  } boh_hist_ctl_t;

endpackage

`default_nettype wire

FILE: src/boh_ram.sv
// ----------------------------------------------------------------------------
// boh_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the new data (write first).
// ----------------------------------------------------------------------------
`default_nettype none

module boh_ram #(
  parameter int Width = 48,
  parameter int Depth = 9,
  localparam int Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, holds its data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/boh_hist.sv
// ----------------------------------------------------------------------------
// boh_hist
// One occupancy histogram: RAM of saturating bins, per-bin valid bits that
// make unwritten bins read as zero, and the read-modify-write of one bin.
// ----------------------------------------------------------------------------
`default_nettype none

module boh_hist #(
  parameter int Depth     = 9,
  parameter int CountBits = 48,
  localparam int Aw       = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire boh_pkg::boh_hist_ctl_t ctl_i,
  input  wire logic [Aw-1:0]          rd_addr_i,
  output logic      [CountBits-1:0]   value_o
);

  import boh_pkg::*;

  logic [Depth-1:0]     vld_q;
  logic                 rvld_q;
  logic                 rvld_d;
  logic [Aw-1:0]        addr_q;
  logic [CountBits-1:0] rdata;
  logic [CountBits-1:0] value;
  logic [CountBits-1:0] bumped;

  // Bin storage
  boh_ram #(
    .Width (CountBits),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.inc_en),
    .waddr_i (addr_q),
    .wdata_i (bumped),
    .re_i    (ctl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // Valid bit of the bin being read, including a write in the same cycle
  assign rvld_d = vld_q[rd_addr_i] | (ctl_i.inc_en & (addr_q == rd_addr_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctl_i.inc_en) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvld_q <= rvld_d;
      end
    end
  end

  // Address of the bin in flight
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      addr_q <= rd_addr_i;
    end
  end

  // Current bin value and its saturating increment
  assign value  = rvld_q ? rdata : '0;
  assign bumped = (&value) ? value : value + CountBits'(1);

  assign value_o = value;

endmodule

`default_nettype wire

FILE: src/busy_occupancy_histogram_unit.sv
// ----------------------------------------------------------------------------
// busy_occupancy_histogram_unit
// Occupancy histograms of busy clusters, DMA engines and vector units, plus
// four saturating busy totals, with a read request for any bin or total.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid_i/in_ready_o | command, busy_clu/dmas/units,
//          |                       | read_bank, read_index
//  out     | out_valid_o/out_ready_i| count_value, index_ok (reads only)
//
//  One request per cycle while in_ready_o is high. Each request reads its
//  bins on acceptance; a tick writes the incremented bins back in the cycle
//  after. The RAM read port returns data written in the same cycle, so
//  back-to-back ticks on one bin are safe. A read result passes through
//  stage two into the output register. in_ready_o drops only while a read
//  result waits in stage two behind a full, stalled output register.
//  Reset clears the totals and the bin valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module busy_occupancy_histogram_unit #(
  parameter int NumClusters = boh_pkg::NumClustersDef,
  parameter int NumUnits    = boh_pkg::NumUnitsDef,
  parameter int CountBits   = boh_pkg::CountBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       command_i,
  input  wire logic [boh_pkg::BusyW-1:0]  busy_clu_i,
  input  wire logic [boh_pkg::BusyW-1:0]  busy_dmas_i,
  input  wire logic [boh_pkg::BusyW-1:0]  busy_units_i,
  input  wire logic [boh_pkg::BankW-1:0]  read_bank_i,
  input  wire logic [boh_pkg::IdxW-1:0]   read_index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [boh_pkg::OutW-1:0]   count_value_o,
  output logic                            index_ok_o
);

  import boh_pkg::*;

  localparam int CluDepth = NumClusters + 1;
  localparam int UnitDepth = NumUnits + 1;
  localparam int CluAw  = $clog2(CluDepth);
  localparam int UnitAw = $clog2(UnitDepth);

  logic accept;
  logic stall;
  logic is_tick;

  // Stage two registers
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_tick_q;
  boh_bank_e            s1_bank_q;
  logic                 s1_ok_q;
  logic [CountBits-1:0] s1_total_q;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [OutW-1:0]      out_count_q;
  logic                 out_ok_q;

  // Totals
  logic [CountBits-1:0] tot_q [NumTotals];
  logic [NumTotals-1:0] tot_bump;

  // Bin and index arithmetic
  logic [CmpW-1:0]      clu_ext, dma_ext, unit_ext, idx_ext;
  logic [CmpW-1:0]      clu_bin, dma_bin, unit_bin;
  logic                 clu_idx_ok, unit_idx_ok;
  logic                 idx_ok;
  logic [CluAw-1:0]     clu_addr, dma_addr;
  logic [UnitAw-1:0]    unit_addr;

  boh_hist_ctl_t        clu_ctl, dma_ctl, unit_ctl;
  logic [CountBits-1:0] clu_val, dma_val, unit_val;
  logic [CountBits-1:0] sel_val;
  logic [MaxCntW-1:0]   sel_wide;

  // Handshake
  assign stall      = s1_valid_q & ~s1_tick_q & out_valid_q & ~out_ready_i;
  assign in_ready_o = ~stall;
  assign accept     = in_valid_i & in_ready_o;
  assign is_tick    = (command_i == CmdTick);

  // Clamp busy counts to the top bin
  assign clu_ext  = CmpW'(busy_clu_i);
  assign dma_ext  = CmpW'(busy_dmas_i);
  assign unit_ext = CmpW'(busy_units_i);
  assign idx_ext  = CmpW'(read_index_i);

  assign clu_bin  = (clu_ext  > CmpW'(NumClusters)) ? CmpW'(NumClusters) : clu_ext;
  assign dma_bin  = (dma_ext  > CmpW'(NumClusters)) ? CmpW'(NumClusters) : dma_ext;
  assign unit_bin = (unit_ext > CmpW'(NumUnits))    ? CmpW'(NumUnits)    : unit_ext;

  assign clu_idx_ok  = (idx_ext <= CmpW'(NumClusters));
  assign unit_idx_ok = (idx_ext <= CmpW'(NumUnits));

  // Bin addresses: busy count for a tick, read index for a read
  always_comb begin
    if (is_tick) begin
      clu_addr  = clu_bin[CluAw-1:0];
      dma_addr  = dma_bin[CluAw-1:0];
      unit_addr = unit_bin[UnitAw-1:0];
    end else begin
      clu_addr  = clu_idx_ok  ? idx_ext[CluAw-1:0]   : '0;
      dma_addr  = clu_idx_ok  ? idx_ext[CluAw-1:0]   : '0;
      unit_addr = unit_idx_ok ? idx_ext[UnitAw-1:0]  : '0;
    end
  end

  // Index range check per bank
  always_comb begin
    unique case (boh_bank_e'(read_bank_i))
      BankCluster: idx_ok = clu_idx_ok;
      BankDma:     idx_ok = clu_idx_ok;
      BankUnit:    idx_ok = unit_idx_ok;
      BankTotal:   idx_ok = (idx_ext < CmpW'(NumTotals));
      default:     idx_ok = 1'b0;
    endcase
  end

  // Histogram control
  always_comb begin
    clu_ctl.rd_en   = accept;
    clu_ctl.inc_en  = s1_valid_q & s1_tick_q;
    dma_ctl         = clu_ctl;
    unit_ctl        = clu_ctl;
  end

  boh_hist #(
    .Depth     (CluDepth),
    .CountBits (CountBits)
  ) u_clu_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (clu_ctl),
    .rd_addr_i (clu_addr),
    .value_o   (clu_val)
  );

  boh_hist #(
    .Depth     (CluDepth),
    .CountBits (CountBits)
  ) u_dma_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (dma_ctl),
    .rd_addr_i (dma_addr),
    .value_o   (dma_val)
  );

  boh_hist #(
    .Depth     (UnitDepth),
    .CountBits (CountBits)
  ) u_unit_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (unit_ctl),
    .rd_addr_i (unit_addr),
    .value_o   (unit_val)
  );

  // Totals: bump on tick acceptance
  always_comb begin
    tot_bump             = '0;
    tot_bump[TotUnit]    = busy_units_i != '0;
    tot_bump[TotDma]     = busy_dmas_i != '0;
    tot_bump[TotCluster] = busy_clu_i != '0;
    tot_bump[TotUnitDma] = (busy_dmas_i != '0) & (busy_units_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTotals; i++) begin
        tot_q[i] <= '0;
      end
    end else if (accept && is_tick) begin
      for (int i = 0; i < NumTotals; i++) begin
        if (tot_bump[i] && !(&tot_q[i])) begin
          tot_q[i] <= tot_q[i] + CountBits'(1);
        end
      end
    end
  end

  // Stage two control
  assign s1_valid_d = stall ? s1_valid_q : accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Stage two payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tick_q  <= is_tick;
      s1_bank_q  <= boh_bank_e'(read_bank_i);
      s1_ok_q    <= idx_ok;
      s1_total_q <= tot_q[read_index_i[TotIdxW-1:0]];
    end
  end

  // Read result selection
  always_comb begin
    unique case (s1_bank_q)
      BankCluster: sel_val = clu_val;
      BankDma:     sel_val = dma_val;
      BankUnit:    sel_val = unit_val;
      BankTotal:   sel_val = s1_total_q;
      default:     sel_val = '0;
    endcase
    if (!s1_ok_q) begin
      sel_val = '0;
    end
  end

  assign sel_wide = MaxCntW'(sel_val);

  // Output register
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if (s1_valid_q && !s1_tick_q && !stall) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && !s1_tick_q && !stall) begin
      out_count_q <= sel_wide[OutW-1:0];
      out_ok_q    <= s1_ok_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign count_value_o = out_count_q;
  assign index_ok_o    = out_ok_q;

endmodule

`default_nettype wire

FILE: src/boh_checker.sv
// ----------------------------------------------------------------------------
// boh_checker
// Port-level checks of the busy-occupancy histogram unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module boh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        command_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [47:0] count_value_o,
  input wire logic        index_ok_o
);

  import boh_pkg::*;

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(count_value_o) && $stable(index_ok_o))
    else $error("result changed while stalled");

  // A new result follows its taken read request through stage two and the output register
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (command_i == CmdRead), 2))
    else $error("result without a read request two cycles earlier");

  // Input backpressure only behind a stalled, full output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Out-of-range reads return zero
  a_bad_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !index_ok_o |-> (count_value_o == '0))
    else $error("nonzero value on a bad index");

endmodule

bind busy_occupancy_histogram_unit boh_checker u_boh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .command_i     (command_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .count_value_o (count_value_o),
  .index_ok_o    (index_ok_o)
);

`default_nettype wire
